FILE: rtl/ordered_key_value_table_defines.svh
// ----------------------------------------------------------------------------
// Ordered key-value table assertion macros
// Shorthand for the concurrent checks used by the table's port checker.
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEY_VALUE_TABLE_DEFINES_SVH
`define ORDERED_KEY_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define OKVT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered key-value table check failed");

// Next-cycle implication, disabled while reset is high.
`define OKVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered key-value table check failed");

`endif

FILE: rtl/okvt_pkg.sv
// ----------------------------------------------------------------------------
// Ordered key-value table package
// Operation and status codes and the command word broadcast to the cells.
// ----------------------------------------------------------------------------
package okvt_pkg;

   typedef enum logic [2:0] {
      OP_SET    = 3'd0,
      OP_GET    = 3'd1,
      OP_ACCESS = 3'd2,
      OP_DELETE = 3'd3,
      OP_CLEAR  = 3'd4,
      OP_READ   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // One command goes to every cell; each cell decides from its own index
   // whether the command concerns it.
   typedef struct packed {
      logic capture;   // Compare the incoming key and hold the match.
      logic update;    // The matching cell takes the new value.
      logic append;    // The first free cell takes the key and new value.
      logic remove;    // Cells from the deleted one upward take their neighbor.
   } cell_cmd_type;

endpackage

FILE: rtl/ordered_key_value_table.sv
// ----------------------------------------------------------------------------
// Ordered key-value table
// Fixed-size key-value table kept in insertion order, built as a row of
// entry cells that compare in parallel and shift down on delete.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  operation, key_in, value_in, position
//   rsp_      out        rsp_valid/rsp_stall  hit, status, key_out, value_out,
//                                             entry_count
//
// When a request is accepted, every cell compares its key with the request
// key and registers a match flag; in the busy state, the match flags are
// reduced to an index and a value, the response is written to the output
// register and the cells update (write, append or shift down).
// No new request is taken until the busy state has finished.
// A stalled response holds the busy state until the output register frees.
// Reset is synchronous and empties the table at once; the entry storage
// itself is never cleared, since only entries below the count are read.
//
module ordered_key_value_table #(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_key_in,
   input  logic [31:0]        req_value_in,
   input  logic [3:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_key_out,
   output logic [31:0]        rsp_value_out,
   output logic [4:0]         rsp_entry_count
);

   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   // The controller is either waiting for a request or finishing one.
   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_BUSY = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   okvt_pkg::op_type       op_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [VALUE_BITS-1:0]  value_ff;
   logic [3:0]             pos_ff;
   logic [CNT_BITS-1:0]    used_ff, used_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff;
   okvt_pkg::status_type   rsp_status_ff;
   logic [31:0]            rsp_key_ff;
   logic [31:0]            rsp_value_ff;
   logic [4:0]             rsp_count_ff;

   logic                   accept;
   logic                   complete;
   logic [KEY_BITS-1:0]    req_key;
   okvt_pkg::cell_cmd_type cmd;
   logic [VALUE_BITS-1:0]  new_value;

   logic [KEY_BITS-1:0]    cell_key   [DEPTH];
   logic [VALUE_BITS-1:0]  cell_value [DEPTH];
   logic [DEPTH-1:0]       match_vec;

   logic                   found_hit;
   logic [IDX_BITS-1:0]    found_index;
   logic [VALUE_BITS-1:0]  found_value;
   logic [KEY_BITS-1:0]    read_key;
   logic [VALUE_BITS-1:0]  read_value;
   logic                   pos_ok;
   logic                   is_full;

   logic                   hit_c;
   okvt_pkg::status_type   status_c;
   logic [KEY_BITS-1:0]    key_c;
   logic [VALUE_BITS-1:0]  value_c;

   // Requests are held off during reset and while one is being finished.
   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // The key is sign-extended from its port width and kept on KEY_BITS bits.
   assign req_key   = KEY_BITS'(req_key_in);

   // The busy state finishes only when the output register can take the
   // response, either because it is empty or because it is being drained.
   assign complete  = (state_ff == S_BUSY) && !(rsp_valid_ff && rsp_stall);

   // Only a Set writes the request value; Access appends a zero value.
   assign new_value = (op_ff == okvt_pkg::OP_SET) ? value_ff : '0;

   // The row of cells. The top cell never shifts, so it is fed its own entry.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [KEY_BITS-1:0]   up_key;
      logic [VALUE_BITS-1:0] up_value;

      if (g == DEPTH - 1) begin : g_top
         assign up_key   = cell_key[g];
         assign up_value = cell_value[g];
      end else begin : g_mid
         assign up_key   = cell_key[g + 1];
         assign up_value = cell_value[g + 1];
      end

      okvt_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS),
         .IDX_BITS   (IDX_BITS),
         .CNT_BITS   (CNT_BITS),
         .INDEX      (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .req_key    (accept ? req_key : key_ff),
         .new_value  (new_value),
         .used       (used_ff),
         .del_index  (found_index),
         .next_key   (up_key),
         .next_value (up_value),
         .key_ff     (cell_key[g]),
         .value_ff   (cell_value[g]),
         .match_ff   (match_vec[g])
      );
   end

   // Keys in the table are unique, so at most one cell matches and the index
   // and value of the match can be gathered by a plain OR across the row.
   always_comb begin
      found_hit   = |match_vec;
      found_index = '0;
      found_value = '0;
      read_key    = '0;
      read_value  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (match_vec[i]) begin
            found_index = found_index | IDX_BITS'(i);
            found_value = found_value | cell_value[i];
         end
         if (32'(pos_ff) == 32'(i)) begin
            read_key   = cell_key[i];
            read_value = cell_value[i];
         end
      end
   end

   assign pos_ok  = 32'(pos_ff) < 32'(used_ff);
   assign is_full = used_ff == CNT_BITS'(DEPTH);

   // Operation decode for the finishing cycle. Cell commands other than capture
   // and the count only take effect when the response is actually written.
   always_comb begin
      cmd         = '0;
      cmd.capture = accept;
      hit_c       = 1'b0;
      status_c    = okvt_pkg::ST_OK;
      key_c       = '0;
      value_c     = '0;
      used_in     = used_ff;
      unique case (op_ff)
         okvt_pkg::OP_SET, okvt_pkg::OP_ACCESS: begin
            if (found_hit) begin
               hit_c      = 1'b1;
               value_c    = (op_ff == okvt_pkg::OP_SET) ? value_ff : found_value;
               cmd.update = complete && (op_ff == okvt_pkg::OP_SET);
            end else if (is_full) begin
               status_c   = okvt_pkg::ST_FULL;
            end else begin
               value_c    = new_value;
               cmd.append = complete;
               used_in    = used_ff + CNT_BITS'(1);
            end
         end
         okvt_pkg::OP_GET: begin
            if (found_hit) begin
               hit_c    = 1'b1;
               value_c  = found_value;
            end else begin
               status_c = okvt_pkg::ST_NOT_FOUND;
            end
         end
         okvt_pkg::OP_DELETE: begin
            if (found_hit) begin
               hit_c      = 1'b1;
               value_c    = found_value;
               cmd.remove = complete;
               used_in    = used_ff - CNT_BITS'(1);
            end else begin
               status_c   = okvt_pkg::ST_NOT_FOUND;
            end
         end
         okvt_pkg::OP_CLEAR: begin
            used_in = '0;
         end
         okvt_pkg::OP_READ: begin
            if (pos_ok) begin
               hit_c    = 1'b1;
               key_c    = read_key;
               value_c  = read_value;
            end else begin
               status_c = okvt_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            // Unused operation codes leave the table as it is.
            used_in = used_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            if (complete) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = complete || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (complete) begin
            used_ff <= used_in;
         end
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= okvt_pkg::op_type'(req_operation);
         key_ff   <= req_key;
         value_ff <= VALUE_BITS'(req_value_in);
         pos_ff   <= req_position;
      end
      if (complete) begin
         rsp_hit_ff    <= hit_c;
         rsp_status_ff <= status_c;
         rsp_key_ff    <= 32'(key_c);
         rsp_value_ff  <= 32'(value_c);
         rsp_count_ff  <= 5'(used_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_key_out     = rsp_key_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

FILE: rtl/okvt_cell.sv
// ----------------------------------------------------------------------------
// Ordered key-value table cell
// Holds one entry, compares it against the request key and shifts down from
// its upper neighbor when the entry at or below it is deleted.
// ----------------------------------------------------------------------------
module okvt_cell #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32,
   parameter int IDX_BITS   = 4,
   parameter int CNT_BITS   = 5,
   parameter int INDEX      = 0
) (
   input  logic                      clock,
   input  okvt_pkg::cell_cmd_type    cmd,
   input  logic [KEY_BITS-1:0]       req_key,
   input  logic [VALUE_BITS-1:0]     new_value,
   input  logic [CNT_BITS-1:0]       used,
   input  logic [IDX_BITS-1:0]       del_index,
   input  logic [KEY_BITS-1:0]       next_key,
   input  logic [VALUE_BITS-1:0]     next_value,
   output logic [KEY_BITS-1:0]       key_ff,
   output logic [VALUE_BITS-1:0]     value_ff,
   output logic                      match_ff
);

   logic [KEY_BITS-1:0]   key_in;
   logic [VALUE_BITS-1:0] value_in;
   logic                  match_in;
   logic                  is_live;
   logic                  is_tail;
   logic                  takes_next;

   assign is_live    = CNT_BITS'(INDEX) < used;
   assign is_tail    = CNT_BITS'(INDEX) == used;
   assign takes_next = (IDX_BITS'(INDEX) >= del_index) && (CNT_BITS'(INDEX + 1) < used);

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      match_in = match_ff;
      if (cmd.capture) begin
         match_in = is_live && (key_ff == req_key);
      end
      priority if (cmd.append && is_tail) begin
         key_in   = req_key;
         value_in = new_value;
      end else if (cmd.update && match_ff) begin
         value_in = new_value;
      end else if (cmd.remove && takes_next) begin
         key_in   = next_key;
         value_in = next_value;
      end else begin
         key_in   = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      match_ff <= match_in;
   end

endmodule

FILE: rtl/okvt_checker.sv
// ----------------------------------------------------------------------------
// Ordered key-value table port checker
// Watches the table's ports over time and flags responses that break its
// handshake or its result rules.
// ----------------------------------------------------------------------------
`include "ordered_key_value_table_defines.svh"

module okvt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [2:0]         req_operation,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_hit,
   input logic [1:0]         rsp_status,
   input logic [4:0]         rsp_entry_count
);

   logic       req_taken;
   logic       fresh_rsp;
   logic       clear_rsp;
   logic       rsp_seen_ff;
   logic       taken1_ff;
   logic       taken2_ff;
   logic [2:0] op1_ff;
   logic [2:0] op2_ff;

   assign req_taken = req_valid && !req_stall;
   assign fresh_rsp = rsp_valid && !rsp_seen_ff;
   assign clear_rsp = fresh_rsp && (op2_ff == okvt_pkg::OP_CLEAR);

   // Delayed copies of the handshake and the request code.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_seen_ff <= 1'b0;
         taken1_ff   <= 1'b0;
         taken2_ff   <= 1'b0;
      end else begin
         rsp_seen_ff <= rsp_valid;
         taken1_ff   <= req_taken;
         taken2_ff   <= taken1_ff;
      end
      op1_ff <= req_operation;
      op2_ff <= op1_ff;
   end

   // A response that waits must still be offered in the next cycle.
   `OKVT_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A hit is always a successful operation.
   `OKVT_ASSERT_IMPLY(a_hit_ok, clock, reset, rsp_valid && rsp_hit, rsp_status == 2'd0)

   // A fresh response follows a request taken, as seen through taken1_ff and taken2_ff.
   `OKVT_ASSERT_IMPLY(a_rsp_from_req, clock, reset, fresh_rsp, taken2_ff)

   // A fresh response to a clear reports an empty table and no hit.
   `OKVT_ASSERT_IMPLY(a_clear_empties, clock, reset, clear_rsp, rsp_entry_count == 5'd0 && !rsp_hit)

endmodule

bind ordered_key_value_table okvt_checker u_okvt_checker (.*);
